// ----- rtl/core/lkm_pkg.sv -----
// ============================================================================
// lkm_pkg: shared types and helpers for the line keyword matcher
// Transfer structs, register indexes, configuration bundle, byte helpers.
// ============================================================================
package lkm_pkg;

    localparam int DEF_KEYWORD_BYTES = 16;
    localparam int DEF_LINE_BYTES    = 2047;
    localparam int DEF_COUNT_BITS    = 24;

    localparam int OUT_COUNT_BITS = 24;
    localparam int KEY_REG_BYTES  = 16;  // bytes held by the two keyword registers
    localparam int KEY_LEN_BITS   = 5;
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_LOW    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_HIGH   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_LEN    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CASE_SENS  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WHOLE_WORD = 3'd4;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [OUT_COUNT_BITS-1:0] line_number;
        logic                      line_matched;
        logic [OUT_COUNT_BITS-1:0] matched_lines;
        logic                      last;
    } out_item_t;

    // Decoded configuration; key_len already clamped to 1..KEYWORD_BYTES
    typedef struct packed {
        logic [8*KEY_REG_BYTES-1:0] keyword;
        logic [KEY_LEN_BITS-1:0]    key_len;
        logic                       raw_case;
        logic                       whole_word;
    } cfg_t;

    function automatic logic [7:0] lkm_fold(input logic [7:0] c, input logic case_sens);
        logic [7:0] r;
        r = c;
        if (!case_sens && (c inside {[8'h41:8'h5A]}))
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    // Keyword byte at idx, folded; positions past the registers read as zero
    function automatic logic [7:0] lkm_key_byte(input logic [8*KEY_REG_BYTES-1:0] kw,
                                                input logic [31:0] idx,
                                                input logic case_sens);
        logic [7:0] b;
        b = 8'd0;
        if (idx < 32'(KEY_REG_BYTES))
        begin
            b = kw[{idx[3:0], 3'b000} +: 8];
        end
        return lkm_fold(b, case_sens);
    endfunction

    function automatic logic lkm_is_delim(input logic [7:0] c);
        return c inside {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h2C, 8'h2E, 8'h3B,
                         8'h3A, 8'h21, 8'h3F, 8'h22, 8'h28, 8'h29};
    endfunction

endpackage

// ----- rtl/core/line_keyword_matcher.sv -----
// ============================================================================
// line_keyword_matcher: per-line keyword search over a byte stream
// Reports once per line whether the configured keyword occurs in it.
// ============================================================================
// Usage:
//  - Input channel (in_valid/in_ready/in_data) takes one text byte per
//    transfer, with end_of_input set on the final byte of a text.
//  - Output channel (out_valid/out_ready/out_data) gives one result per line:
//    line index, hit flag, running hit count and a last flag. Lines end at
//    LF, after LINE_BYTES bytes, or at the end_of_input byte.
//  - Throughput: one byte per cycle unless the output stalls. The whole
//    per-byte update (window and token compares, counters) is combinational.
//  - Latency: a result is in the output register the cycle after the byte
//    that ends its line is transferred.
//  - Stall: the output register holds its result until taken; in_ready drops
//    only while a result is held and out_ready is low.
//  - Reset (rst_n low, async) empties the output register, zeroes counters
//    and line state, and restores the register defaults (length 1, case
//    folded, substring mode).
//  - Configuration is a write-only port; write only while the block is idle.
// ============================================================================
module line_keyword_matcher #(
    parameter int KEYWORD_BYTES = lkm_pkg::DEF_KEYWORD_BYTES,
    parameter int LINE_BYTES    = lkm_pkg::DEF_LINE_BYTES,
    parameter int COUNT_BITS    = lkm_pkg::DEF_COUNT_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [lkm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [lkm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  lkm_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output lkm_pkg::out_item_t                  out_data
);
    import lkm_pkg::*;

    localparam int FILL_W = $clog2(LINE_BYTES + 1);
    localparam int TOK_W  = $clog2(KEYWORD_BYTES + 2);

    cfg_t cfg;

    // line and token state
    logic [FILL_W-1:0]     line_fill_reg,  line_fill_next;
    logic [TOK_W-1:0]      tok_len_reg,    tok_len_next;
    logic                  tok_eq_reg,     tok_eq_next;
    logic                  line_hit_reg,   line_hit_next;
    logic                  zero_seen_reg,  zero_seen_next;
    logic [COUNT_BITS-1:0] line_cnt_reg,   line_cnt_next;
    logic [COUNT_BITS-1:0] hit_cnt_reg,    hit_cnt_next;

    // output register
    logic      out_valid_reg;
    out_item_t out_data_reg, out_data_next;

    logic                  fire;
    logic                  win_match;
    logic [7:0]            c;
    logic [7:0]            c_fold;
    logic                  eoi;
    logic                  delim;
    logic                  active;
    logic                  tok_close_old;
    logic                  tok_mismatch;
    logic                  tok_eq_app;
    logic [TOK_W-1:0]      tok_len_app;
    logic                  tok_close_app;
    logic [FILL_W-1:0]     fill_inc;
    logic                  line_end;
    logic                  word_break;
    logic                  word_app;
    logic                  sub_hit;
    logic                  hit_now;
    logic [COUNT_BITS-1:0] hit_cnt_upd;
    logic [COUNT_BITS-1:0] line_cnt_upd;

    lkm_cfg_regs #(
        .KEYWORD_BYTES(KEYWORD_BYTES)
    ) u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lkm_window #(
        .KEYWORD_BYTES(KEYWORD_BYTES)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (fire),
        .text_byte (in_data.text_byte),
        .cfg       (cfg),
        .match     (win_match)
    );

    // a new byte enters whenever the output register is free or being drained
    assign in_ready  = !out_valid_reg || out_ready;
    assign fire      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        c      = in_data.text_byte;
        eoi    = in_data.end_of_input;
        c_fold = lkm_fold(c, cfg.raw_case);
        delim  = lkm_is_delim(c);
        // once a zero byte shows up, the rest of the line is ignored
        active = !zero_seen_reg && (c != 8'd0);

        // whole-word: close the current token, or extend it by this byte
        tok_close_old = (tok_len_reg != '0) && (32'(tok_len_reg) == 32'(cfg.key_len)) &&
                        tok_eq_reg;
        tok_mismatch  = (32'(tok_len_reg) >= 32'(cfg.key_len)) ||
                        (c_fold != lkm_key_byte(cfg.keyword, 32'(tok_len_reg),
                                                cfg.raw_case));
        tok_eq_app    = tok_eq_reg && !tok_mismatch;
        tok_len_app   = (32'(tok_len_reg) <= 32'(KEYWORD_BYTES)) ?
                        tok_len_reg + TOK_W'(1) : tok_len_reg;
        tok_close_app = (tok_len_app != '0) && (32'(tok_len_app) == 32'(cfg.key_len)) &&
                        tok_eq_app;

        fill_inc = (line_fill_reg < FILL_W'(LINE_BYTES)) ?
                   line_fill_reg + FILL_W'(1) : line_fill_reg;
        line_end = (c == 8'h0A) || (fill_inc >= FILL_W'(LINE_BYTES)) || eoi;

        word_break = cfg.whole_word && !zero_seen_reg && ((c == 8'd0) || delim);
        word_app   = cfg.whole_word && active && !delim;
        // substring: enough bytes of this line in the window to hold the key
        sub_hit    = !cfg.whole_word && active && win_match &&
                     (32'(line_fill_reg) + 32'd1 >= 32'(cfg.key_len));

        hit_now = line_hit_reg || (word_break && tok_close_old) ||
                  (word_app && line_end && tok_close_app) || sub_hit;

        hit_cnt_upd  = (hit_now && (hit_cnt_reg != '1)) ?
                       hit_cnt_reg + COUNT_BITS'(1) : hit_cnt_reg;
        line_cnt_upd = (line_cnt_reg != '1) ? line_cnt_reg + COUNT_BITS'(1) : line_cnt_reg;

        out_data_next.line_number   = OUT_COUNT_BITS'(line_cnt_reg);
        out_data_next.line_matched  = hit_now;
        out_data_next.matched_lines = OUT_COUNT_BITS'(hit_cnt_upd);
        out_data_next.last          = eoi;

        // defaults: hold
        line_fill_next = line_fill_reg;
        tok_len_next   = tok_len_reg;
        tok_eq_next    = tok_eq_reg;
        line_hit_next  = line_hit_reg;
        zero_seen_next = zero_seen_reg;
        line_cnt_next  = line_cnt_reg;
        hit_cnt_next   = hit_cnt_reg;

        if (line_end)
        begin
            line_fill_next = '0;
            tok_len_next   = '0;
            tok_eq_next    = 1'b1;
            line_hit_next  = 1'b0;
            zero_seen_next = 1'b0;
            // the final line of a text starts the counts over
            line_cnt_next  = eoi ? '0 : line_cnt_upd;
            hit_cnt_next   = eoi ? '0 : hit_cnt_upd;
        end
        else
        begin
            line_fill_next = fill_inc;
            line_hit_next  = hit_now;
            zero_seen_next = zero_seen_reg || (c == 8'd0);
            if (word_break)
            begin
                tok_len_next = '0;
                tok_eq_next  = 1'b1;
            end
            else if (word_app)
            begin
                tok_len_next = tok_len_app;
                tok_eq_next  = tok_eq_app;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_fill_reg <= '0;
            tok_len_reg   <= '0;
            tok_eq_reg    <= 1'b1;
            line_hit_reg  <= 1'b0;
            zero_seen_reg <= 1'b0;
            line_cnt_reg  <= '0;
            hit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                line_fill_reg <= line_fill_next;
                tok_len_reg   <= tok_len_next;
                tok_eq_reg    <= tok_eq_next;
                line_hit_reg  <= line_hit_next;
                zero_seen_reg <= zero_seen_next;
                line_cnt_reg  <= line_cnt_next;
                hit_cnt_reg   <= hit_cnt_next;
            end
            if (fire && line_end)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && line_end)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ----- rtl/core/lkm_cfg_regs.sv -----
// ============================================================================
// lkm_cfg_regs: configuration register file
// Write-only registers, decoded into one bundle with the length clamped.
// ============================================================================
module lkm_cfg_regs #(
    parameter int KEYWORD_BYTES = lkm_pkg::DEF_KEYWORD_BYTES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [lkm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [lkm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output lkm_pkg::cfg_t                       cfg
);
    import lkm_pkg::*;

    logic [CFG_DATA_BITS-1:0] key_low_reg;
    logic [CFG_DATA_BITS-1:0] key_high_reg;
    logic [KEY_LEN_BITS-1:0]  key_len_reg;
    logic                     case_sens_reg;
    logic                     whole_word_reg;
    logic [KEY_LEN_BITS-1:0]  len_clamped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            key_len_reg    <= KEY_LEN_BITS'(1);
            case_sens_reg  <= 1'b0;
            whole_word_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_KEY_LOW:    key_low_reg    <= cfg_data;
                REG_KEY_HIGH:   key_high_reg   <= cfg_data;
                REG_KEY_LEN:    key_len_reg    <= cfg_data[KEY_LEN_BITS-1:0];
                REG_CASE_SENS:  case_sens_reg  <= cfg_data[0];
                REG_WHOLE_WORD: whole_word_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // zero reads as one, anything past the keyword size as the size
    always_comb
    begin
        len_clamped = key_len_reg;
        if (key_len_reg == '0)
        begin
            len_clamped = KEY_LEN_BITS'(1);
        end
        else if (32'(key_len_reg) > 32'(KEYWORD_BYTES))
        begin
            len_clamped = KEY_LEN_BITS'(KEYWORD_BYTES);
        end
    end

    assign cfg.keyword    = {key_high_reg, key_low_reg};
    assign cfg.key_len    = len_clamped;
    assign cfg.raw_case   = case_sens_reg;
    assign cfg.whole_word = whole_word_reg;

endmodule

// ----- rtl/core/lkm_window.sv -----
// ============================================================================
// lkm_window: recent-byte window and parallel keyword compare
// Flags when the current byte closes a keyword occurrence ending here.
// ============================================================================
module lkm_window #(
    parameter int KEYWORD_BYTES = lkm_pkg::DEF_KEYWORD_BYTES
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          shift_en,
    input  logic [7:0]    text_byte,
    input  lkm_pkg::cfg_t cfg,
    output logic          match
);
    import lkm_pkg::*;

    localparam int WIN = (KEYWORD_BYTES > 1) ? KEYWORD_BYTES - 1 : 1;

    logic [7:0]     recent_reg [WIN];
    logic [WIN-1:0] lane_ok;
    logic           head_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN; i++)
            begin
                recent_reg[i] <= 8'd0;
            end
        end
        else if (shift_en)
        begin
            recent_reg[0] <= text_byte;
            for (int i = 1; i < WIN; i++)
            begin
                recent_reg[i] <= recent_reg[i-1];
            end
        end
    end

    // lane i holds the byte i+1 back; it lines up with keyword byte len-2-i
    always_comb
    begin
        for (int i = 0; i < WIN; i++)
        begin
            lane_ok[i] = (32'(i) + 32'd2 > 32'(cfg.key_len)) ||
                         (lkm_fold(recent_reg[i], cfg.raw_case) ==
                          lkm_key_byte(cfg.keyword,
                                       32'(cfg.key_len) - 32'(i) - 32'd2,
                                       cfg.raw_case));
        end
        head_ok = lkm_fold(text_byte, cfg.raw_case) ==
                  lkm_key_byte(cfg.keyword, 32'(cfg.key_len) - 32'd1, cfg.raw_case);
    end

    assign match = head_ok && (&lane_ok);

endmodule

// ----- rtl/core/lkm_checker.sv -----
// ============================================================================
// lkm_checker: port-level checks for the line keyword matcher
// Watches the top-level ports; attached by bind.
// ============================================================================
module lkm_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input lkm_pkg::in_item_t                   in_data,
    input logic                                out_valid,
    input logic                                out_ready,
    input lkm_pkg::out_item_t                  out_data
);
    import lkm_pkg::*;

    // a held result stays put until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("lkm: output transfer dropped or changed while stalled");

    // a waiting input transfer stays put until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("lkm: input transfer dropped or changed while waiting");

    // input backpressure only comes from a stalled output register
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("lkm: in_ready low without output stall");

    // a matched line is counted in matched_lines
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.line_matched |-> out_data.matched_lines != '0)
        else $error("lkm: matched line with zero hit count");

    // never more hits than lines reported
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, out_data.matched_lines} <=
                       {1'b0, out_data.line_number} + (OUT_COUNT_BITS + 1)'(1)))
        else $error("lkm: hit count exceeds line count");

endmodule

bind line_keyword_matcher lkm_checker u_lkm_checker (.*);
